FILE: hw/rtl/shake_gesture_detector_assert.svh
// Assertion macros used by the shake detector merge module (sgd_merge).
// Each expects clk and arst_n in scope.
`ifndef SHAKE_GESTURE_DETECTOR_ASSERT_SVH
`define SHAKE_GESTURE_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SGD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define SGD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SGD_ASSERT_IMP(lbl, ante, cons)
`define SGD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/sgd_pkg.sv
package sgd_pkg;

	localparam int unsigned NUM_LANES = 6;

	localparam logic [2:0] REG_LEVEL_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_MIN_PULSE       = 3'd1;
	localparam logic [2:0] REG_RELEASE         = 3'd2;
	localparam logic [2:0] REG_SWINGS_NEEDED   = 3'd3;
	localparam logic [2:0] REG_CLEAR_SHORT     = 3'd4;
	localparam logic [2:0] REG_CLEAR_LONG      = 3'd5;

	localparam logic [14:0] LEVEL_THRESHOLD_RST = 15'd5000;
	localparam logic [7:0]  MIN_PULSE_RST       = 8'd6;
	localparam logic [2:0]  RELEASE_RST         = 3'd6;
	localparam logic [7:0]  SWINGS_NEEDED_RST   = 8'd4;
	localparam logic [11:0] CLEAR_SHORT_RST     = 12'd140;
	localparam logic [11:0] CLEAR_LONG_RST      = 12'd200;

	localparam logic [7:0] BEYOND_MAX = 8'hFF;
	localparam logic [2:0] INSIDE_MAX = 3'h7;
	localparam logic [7:0] SWING_MAX  = 8'hFF;

	typedef struct packed {
		logic [14:0] level_threshold;
		logic [7:0]  min_pulse_samples;
		logic [2:0]  release_samples;
		logic [7:0]  swings_needed;
		logic [11:0] clear_delay_short;
		logic [11:0] clear_delay_long;
	} cfg_t;

	typedef struct packed {
		logic advance;
		logic wipe;
	} lane_ctl_t;

endpackage

FILE: hw/rtl/sgd_lane.sv
module sgd_lane
	import sgd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  lane_ctl_t   ctl,
	input  cfg_t        cfg,
	input  logic        neg,
	input  logic [15:0] sample,
	output logic        swing_done
);

	logic [7:0]  beyond_q;
	logic [2:0]  inside_q;
	logic [7:0]  beyond_cur;
	logic [2:0]  inside_cur;
	logic [7:0]  beyond_nxt;
	logic [2:0]  inside_nxt;
	logic [2:0]  inside_inc;
	logic signed [16:0] s_ext;
	logic signed [16:0] thr_pos;
	logic signed [16:0] thr_neg;
	logic        beyond;

	assign s_ext   = $signed({sample[15], sample});
	assign thr_pos = $signed({2'b00, cfg.level_threshold});
	assign thr_neg = 17'sd0 - thr_pos;
	assign beyond  = neg ? (s_ext < thr_neg) : (s_ext >= thr_pos);

	assign beyond_cur = ctl.wipe ? 8'd0 : beyond_q;
	assign inside_cur = ctl.wipe ? 3'd0 : inside_q;
	assign inside_inc = (inside_cur < INSIDE_MAX) ? inside_cur + 3'd1 : INSIDE_MAX;

	always_comb begin
		beyond_nxt = beyond_cur;
		inside_nxt = inside_cur;
		swing_done = 1'b0;
		if (beyond) begin
			beyond_nxt = (beyond_cur < BEYOND_MAX) ? beyond_cur + 8'd1 : BEYOND_MAX;
			inside_nxt = 3'd0;
		end else if (beyond_cur >= cfg.min_pulse_samples) begin
			if (inside_inc >= cfg.release_samples) begin
				beyond_nxt = 8'd0;
				inside_nxt = 3'd0;
				swing_done = 1'b1;
			end else begin
				inside_nxt = inside_inc;
			end
		end else begin
			beyond_nxt = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beyond_q <= 8'd0;
			inside_q <= 3'd0;
		end else if (ctl.advance) begin
			beyond_q <= beyond_nxt;
			inside_q <= inside_nxt;
		end
	end

endmodule

FILE: hw/rtl/sgd_merge.sv
`include "shake_gesture_detector_assert.svh"
module sgd_merge
	import sgd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  cfg_t                 cfg,
	input  logic [NUM_LANES-1:0] swing_done,
	output logic                 wipe,
	output logic                 fired
);

	logic        armed_q;
	logic [7:0]  swings_q;
	logic [11:0] countdown_q;
	logic        armed_nxt;
	logic [7:0]  swings_nxt;
	logic [11:0] countdown_nxt;

	assign wipe = (countdown_q == 12'd1);

	// Resolve completed swings in lane order: z+, z-, y+, y-, x+, x-.
	always_comb begin
		armed_nxt     = wipe ? 1'b0 : armed_q;
		swings_nxt    = wipe ? 8'd0 : swings_q;
		countdown_nxt = (countdown_q != 12'd0) ? countdown_q - 12'd1 : 12'd0;
		fired         = 1'b0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (swing_done[i]) begin
				if (!armed_nxt) begin
					armed_nxt = 1'b1;
				end else begin
					if (swings_nxt < SWING_MAX)
						swings_nxt = swings_nxt + 8'd1;
					if (swings_nxt > cfg.swings_needed) begin
						countdown_nxt = cfg.clear_delay_long;
						fired         = 1'b1;
					end else begin
						countdown_nxt = cfg.clear_delay_short;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			swings_q    <= 8'd0;
			countdown_q <= 12'd0;
		end else if (advance) begin
			armed_q     <= armed_nxt;
			swings_q    <= swings_nxt;
			countdown_q <= countdown_nxt;
		end
	end

	`SGD_ASSERT_IMP(a_count_needs_arm, !armed_q, swings_q == 8'd0)
	`SGD_ASSERT_NXT(a_fire_leaves_armed, advance && fired, armed_q)
	`SGD_ASSERT_NXT(a_fire_loads_long, advance && fired, countdown_q == $past(cfg.clear_delay_long))
	`SGD_ASSERT_NXT(a_idle_countdown_holds, !advance, $stable(countdown_q))

endmodule

FILE: hw/rtl/shake_gesture_detector.sv
// Shake gesture detector. Each input beat carries one three-axis sample;
// each sample yields exactly one output beat whose bit 0 is set when a shake
// completed on that sample. Six direction lanes (z+, z-, y+, y-, x+, x-)
// track beyond-threshold runs and releases in parallel; a merge stage
// resolves their completed swings in that order against the shared window,
// swing count and clear countdown. One sample is taken every clock: all
// per-sample work is done in the accepting cycle and the result sits in an
// output register, so the input stalls only while that register is full and
// the downstream side holds tready low. Registers are written through the
// config channel, which is always ready; writes to indexes 6 and 7 are
// ignored.
module shake_gesture_detector
	import sgd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [0] shake_detected, [7:1] zero
);

	cfg_t                 cfg_q;
	lane_ctl_t            lane_ctl;
	logic                 advance;
	logic                 wipe;
	logic                 fired;
	logic [NUM_LANES-1:0] swing_done;
	logic [15:0]          lane_sample [NUM_LANES];
	logic                 out_valid_q;
	logic                 out_shake_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_threshold   <= LEVEL_THRESHOLD_RST;
			cfg_q.min_pulse_samples <= MIN_PULSE_RST;
			cfg_q.release_samples   <= RELEASE_RST;
			cfg_q.swings_needed     <= SWINGS_NEEDED_RST;
			cfg_q.clear_delay_short <= CLEAR_SHORT_RST;
			cfg_q.clear_delay_long  <= CLEAR_LONG_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LEVEL_THRESHOLD: cfg_q.level_threshold   <= cfg_data;
				REG_MIN_PULSE:       cfg_q.min_pulse_samples <= cfg_data[7:0];
				REG_RELEASE:         cfg_q.release_samples   <= cfg_data[2:0];
				REG_SWINGS_NEEDED:   cfg_q.swings_needed     <= cfg_data[7:0];
				REG_CLEAR_SHORT:     cfg_q.clear_delay_short <= cfg_data[11:0];
				REG_CLEAR_LONG:      cfg_q.clear_delay_long  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready    = !out_valid_q || m_axis_tready;
	assign advance          = s_axis_tvalid && s_axis_tready;
	assign lane_ctl.advance = advance;
	assign lane_ctl.wipe    = wipe;

	assign lane_sample[0] = s_axis_tdata[47:32];
	assign lane_sample[1] = s_axis_tdata[47:32];
	assign lane_sample[2] = s_axis_tdata[31:16];
	assign lane_sample[3] = s_axis_tdata[31:16];
	assign lane_sample[4] = s_axis_tdata[15:0];
	assign lane_sample[5] = s_axis_tdata[15:0];

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		sgd_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (lane_ctl),
			.cfg        (cfg_q),
			.neg        (g % 2 == 1),
			.sample     (lane_sample[g]),
			.swing_done (swing_done[g])
		);
	end

	sgd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.cfg        (cfg_q),
		.swing_done (swing_done),
		.wipe       (wipe),
		.fired      (fired)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_shake_q <= 1'b0;
		end else if (advance) begin
			out_shake_q <= fired;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_shake_q};

endmodule
